// ===== sv/range_and_direction_3d_assert.svh =====
// Assertion macros for range_and_direction_3d
`ifndef RANGE_AND_DIRECTION_3D_ASSERT_SVH
`define RANGE_AND_DIRECTION_3D_ASSERT_SVH

`ifndef SYNTHESIS
`define RAD_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
`define RAD_ASSERT_IMPL(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed");
`else
`define RAD_ASSERT(lbl, clk, rst_n, prop)
`define RAD_ASSERT_IMPL(lbl, clk, rst_n, pre, post)
`endif

`endif

// ===== sv/rad_pkg.sv =====
package rad_pkg;
  localparam int unsigned CoordW  = 24;
  localparam int unsigned DiffW   = 25;
  localparam int unsigned SumW    = 50;
  localparam int unsigned RootW   = 25;
  localparam int unsigned RemW    = 27;
  localparam int unsigned DirFrac = 14;
  localparam int unsigned QuotW   = DirFrac + 1;
  localparam int unsigned DirW    = 16;
  localparam int unsigned NumAxes = 3;
endpackage

// ===== sv/range_and_direction_3d.sv =====
// range_and_direction_3d
// Input channel: in_valid_i/in_ready_o carry one request of beacon and
// estimate coordinates (signed Q12.12). Output channel: out_valid_o/
// out_ready_i carry distance (unsigned Q13.12, truncated root), the unit
// vector from beacon to estimate (signed Q1.14, truncated) and a flag
// raised when the distance is zero, with the direction forced to zero.
// Stages: difference, square, sum, 25 root stages (one result bit each),
// divider load, 15 divider stages (one quotient bit each, three axes in
// parallel) and the output register. Throughput is one request per cycle
// unless the receiver holds the output; the whole pipeline advances together,
// and while it is held every stage holds and in_ready_o is low, so nothing is
// lost or repeated. Reset clears only the valid bits, not the data registers.
module range_and_direction_3d (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [rad_pkg::CoordW-1:0]   beacon_x_i,
  input  logic signed [rad_pkg::CoordW-1:0]   beacon_y_i,
  input  logic signed [rad_pkg::CoordW-1:0]   beacon_z_i,
  input  logic signed [rad_pkg::CoordW-1:0]   est_x_i,
  input  logic signed [rad_pkg::CoordW-1:0]   est_y_i,
  input  logic signed [rad_pkg::CoordW-1:0]   est_z_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic        [rad_pkg::RootW-1:0]    distance_o,
  output logic signed [rad_pkg::DirW-1:0]     dir_x_o,
  output logic signed [rad_pkg::DirW-1:0]     dir_y_o,
  output logic signed [rad_pkg::DirW-1:0]     dir_z_o,
  output logic                                zero_distance_o
);
  import rad_pkg::*;

  localparam int unsigned SqSt = RootW;
  localparam int unsigned DvSt = QuotW;

  logic en;

  // difference stage
  logic                 va_q;
  logic [DiffW-1:0]     mag_a_q [NumAxes];
  logic [NumAxes-1:0]   neg_a_q;
  logic signed [DiffW-1:0] diff_d [NumAxes];
  logic signed [CoordW-1:0] est_v [NumAxes];
  logic signed [CoordW-1:0] bcn_v [NumAxes];

  // square stage
  logic                 vb_q;
  logic [SumW-1:0]      sq_b_q [NumAxes];
  logic [DiffW-1:0]     mag_b_q [NumAxes];
  logic [NumAxes-1:0]   neg_b_q;

  // root stages
  logic                 vs_q   [SqSt+1];
  logic [SumW-1:0]      rad_q  [SqSt+1];
  logic [RemW-1:0]      rem_q  [SqSt+1];
  logic [RootW-1:0]     root_q [SqSt+1];
  logic [DiffW-1:0]     mag_s_q [SqSt+1][NumAxes];
  logic [NumAxes-1:0]   neg_s_q [SqSt+1];

  // divider stages
  logic                 vd_q   [DvSt+1];
  logic [RootW-1:0]     dist_d_q [DvSt+1];
  logic [RootW-1:0]     r_q    [DvSt+1][NumAxes];
  logic [QuotW-1:0]     qt_q   [DvSt+1][NumAxes];
  logic [NumAxes-1:0]   neg_d_q [DvSt+1];

  // output
  logic                 vo_q;
  logic [RootW-1:0]     dist_o_q;
  logic [DirW-1:0]      dir_o_q [NumAxes];
  logic                 zero_o_q;

  assign en         = !vo_q || out_ready_i;
  assign in_ready_o = en;

  assign est_v[0] = est_x_i;
  assign est_v[1] = est_y_i;
  assign est_v[2] = est_z_i;
  assign bcn_v[0] = beacon_x_i;
  assign bcn_v[1] = beacon_y_i;
  assign bcn_v[2] = beacon_z_i;

  always_comb begin
    for (int a = 0; a < NumAxes; a++) begin
      diff_d[a] = DiffW'(est_v[a]) - DiffW'(bcn_v[a]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else if (en) begin
      va_q <= in_valid_i;
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int a = 0; a < NumAxes; a++) begin
        neg_a_q[a] <= diff_d[a][DiffW-1];
        mag_a_q[a] <= diff_d[a][DiffW-1] ? DiffW'(-diff_d[a]) : DiffW'(diff_d[a]);
        sq_b_q[a]  <= SumW'(mag_a_q[a] * mag_a_q[a]);
        mag_b_q[a] <= mag_a_q[a];
      end
      neg_b_q <= neg_a_q;
    end
  end

  // sum stage feeds root stage 0
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vs_q[0] <= 1'b0;
    end else if (en) begin
      vs_q[0] <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rad_q[0]   <= sq_b_q[0] + sq_b_q[1] + sq_b_q[2];
      rem_q[0]   <= '0;
      root_q[0]  <= '0;
      mag_s_q[0] <= mag_b_q;
      neg_s_q[0] <= neg_b_q;
    end
  end

  for (genvar k = 0; k < SqSt; k++) begin : g_sqrt
    logic [RemW+1:0] remsh;
    logic [RemW+1:0] trial;
    logic            take;

    assign remsh = {rem_q[k], rad_q[k][SumW-1 -: 2]};
    assign trial = (RemW+2)'({root_q[k], 2'b01});
    assign take  = remsh >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vs_q[k+1] <= 1'b0;
      end else if (en) begin
        vs_q[k+1] <= vs_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        rad_q[k+1]   <= {rad_q[k][SumW-3:0], 2'b00};
        rem_q[k+1]   <= take ? RemW'(remsh - trial) : RemW'(remsh);
        root_q[k+1]  <= {root_q[k][RootW-2:0], take};
        mag_s_q[k+1] <= mag_s_q[k];
        neg_s_q[k+1] <= neg_s_q[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vd_q[0] <= 1'b0;
    end else if (en) begin
      vd_q[0] <= vs_q[SqSt];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dist_d_q[0] <= root_q[SqSt];
      r_q[0]      <= mag_s_q[SqSt];
      neg_d_q[0]  <= neg_s_q[SqSt];
      for (int a = 0; a < NumAxes; a++) begin
        qt_q[0][a] <= '0;
      end
    end
  end

  for (genvar j = 0; j < DvSt; j++) begin : g_div
    logic [RootW:0]   rt [NumAxes];
    logic [NumAxes-1:0] ge;

    always_comb begin
      for (int a = 0; a < NumAxes; a++) begin
        rt[a] = (j == 0) ? {1'b0, r_q[j][a]} : {r_q[j][a], 1'b0};
        ge[a] = rt[a] >= {1'b0, dist_d_q[j]};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vd_q[j+1] <= 1'b0;
      end else if (en) begin
        vd_q[j+1] <= vd_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        dist_d_q[j+1] <= dist_d_q[j];
        neg_d_q[j+1]  <= neg_d_q[j];
        for (int a = 0; a < NumAxes; a++) begin
          r_q[j+1][a]  <= ge[a] ? RootW'(rt[a] - {1'b0, dist_d_q[j]}) : RootW'(rt[a]);
          qt_q[j+1][a] <= {qt_q[j][a][QuotW-2:0], ge[a]};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else if (en) begin
      vo_q <= vd_q[DvSt];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dist_o_q <= dist_d_q[DvSt];
      zero_o_q <= dist_d_q[DvSt] == '0;
      for (int a = 0; a < NumAxes; a++) begin
        if (dist_d_q[DvSt] == '0) begin
          dir_o_q[a] <= '0;
        end else if (neg_d_q[DvSt][a]) begin
          dir_o_q[a] <= DirW'(-{1'b0, qt_q[DvSt][a]});
        end else begin
          dir_o_q[a] <= DirW'({1'b0, qt_q[DvSt][a]});
        end
      end
    end
  end

  assign out_valid_o     = vo_q;
  assign distance_o      = dist_o_q;
  assign dir_x_o         = dir_o_q[0];
  assign dir_y_o         = dir_o_q[1];
  assign dir_z_o         = dir_o_q[2];
  assign zero_distance_o = zero_o_q;

`include "range_and_direction_3d_assert.svh"

  `RAD_ASSERT_IMPL(a_zero_dir, clk_i, rst_ni, out_valid_o && zero_distance_o,
                   dir_x_o == '0 && dir_y_o == '0 && dir_z_o == '0)
  `RAD_ASSERT_IMPL(a_zero_flag, clk_i, rst_ni, out_valid_o,
                   zero_distance_o == (distance_o == '0))
  `RAD_ASSERT(a_ready, clk_i, rst_ni, in_ready_o == (!out_valid_o || out_ready_i))

endmodule

// ===== test/tb_range_and_direction_3d.sv =====
module tb_range_and_direction_3d;
  timeunit 1ns;
  timeprecision 1ps;
  import rad_pkg::*;

  typedef struct packed {
    logic signed [CoordW-1:0] bx, by, bz, ex, ey, ez;
  } coords_t;

  typedef struct packed {
    logic [RootW-1:0]       distance;
    logic signed [DirW-1:0] dx, dy, dz;
    logic                   zero;
  } range_dir_t;

  localparam int NumRandom = 1430;
  localparam int PipeLat   = 45;

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready;
  logic signed [CoordW-1:0] bx, by, bz, ex, ey, ez;
  logic [RootW-1:0] dist_o;
  logic signed [DirW-1:0] dx_o, dy_o, dz_o;
  logic zero_o;

  coords_t    pending_q[$];
  range_dir_t expected_q[$];
  int n_err = 0, n_sent = 0, n_got = 0, n_zero = 0;
  int idle_in = 0, idle_out = 0;
  bit quiet = 0;
  bit hold_long = 0;
  bit stim_done = 0;

  range_and_direction_3d uut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .beacon_x_i(bx), .beacon_y_i(by), .beacon_z_i(bz),
    .est_x_i(ex), .est_y_i(ey), .est_z_i(ez),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .distance_o(dist_o), .dir_x_o(dx_o), .dir_y_o(dy_o), .dir_z_o(dz_o),
    .zero_distance_o(zero_o)
  );

  function automatic longint unsigned root_floor(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic logic [DirW-1:0] unit_comp(longint d, longint unsigned rng);
    longint unsigned q, a;
    if (rng == 0) return '0;
    a = (d < 0) ? -d : d;
    q = (a << DirFrac) / rng;
    if (d < 0) q = -q;
    return q[DirW-1:0];
  endfunction

  function automatic range_dir_t range_dir(coords_t c);
    range_dir_t r;
    longint d0, d1, d2;
    longint unsigned s, rt;
    d0 = longint'(c.ex) - longint'(c.bx);
    d1 = longint'(c.ey) - longint'(c.by);
    d2 = longint'(c.ez) - longint'(c.bz);
    s = d0 * d0 + d1 * d1 + d2 * d2;
    rt = root_floor(s);
    r.distance = rt[RootW-1:0];
    r.dx = unit_comp(d0, rt);
    r.dy = unit_comp(d1, rt);
    r.dz = unit_comp(d2, rt);
    r.zero = (rt == 0);
    return r;
  endfunction

  function automatic logic [CoordW-1:0] rnd_coord();
    case ($urandom_range(0, 5))
      0: return 24'h7FFFFF;
      1: return 24'h800000;
      2: return $urandom_range(0, 31) - 16;
      3: return $urandom_range(0, 8191) - 4096;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    coords_t c;
    logic [CoordW-1:0] mx, mn;
    mx = 24'h7FFFFF;
    mn = 24'h800000;
    pending_q.push_back('{0, 0, 0, 0, 0, 0});
    pending_q.push_back('{mx, mx, mx, mx, mx, mx});
    pending_q.push_back('{mn, mn, mn, mn, mn, mn});
    pending_q.push_back('{mn, mn, mn, mx, mx, mx});
    pending_q.push_back('{mx, mx, mx, mn, mn, mn});
    pending_q.push_back('{mx, 0, 0, mn, 0, 0});
    pending_q.push_back('{0, mn, 0, 0, mx, 0});
    pending_q.push_back('{0, 0, mx, 0, 0, mn});
    pending_q.push_back('{0, 0, 0, 1, 0, 0});
    pending_q.push_back('{0, 0, 0, 0, -1, 0});
    pending_q.push_back('{0, 0, 0, 0, 0, 1});
    pending_q.push_back('{0, 0, 0, 1, 1, 1});
    pending_q.push_back('{0, 0, 0, -1, -1, -1});
    pending_q.push_back('{5, -7, 9, 5, -7, 9});
    pending_q.push_back('{mx, mn, 1, mx, mn, 1});
    pending_q.push_back('{0, 0, 0, 3, 4, 0});
    pending_q.push_back('{24'h555555, 24'hAAAAAA, 0, 24'hAAAAAA, 24'h555555, 0});
    for (int i = 0; i < NumRandom; i++) begin
      c.bx = rnd_coord(); c.by = rnd_coord(); c.bz = rnd_coord();
      if ($urandom_range(0, 19) == 0) begin
        c.ex = c.bx; c.ey = c.by; c.ez = c.bz;
      end else if ($urandom_range(0, 3) == 0) begin
        c.ex = c.bx + $urandom_range(0, 63) - 32;
        c.ey = c.by + $urandom_range(0, 63) - 32;
        c.ez = c.bz + $urandom_range(0, 63) - 32;
      end else begin
        c.ex = rnd_coord(); c.ey = rnd_coord(); c.ez = rnd_coord();
      end
      pending_q.push_back(c);
    end
  end

  // driver
  always @(posedge clk or negedge rst_n) begin
    coords_t c;
    bit go_idle;
    if (!rst_n) begin
      in_valid <= 0;
      {bx, by, bz, ex, ey, ez} <= '0;
    end else begin
      if (in_valid && in_ready) begin
        expected_q.push_back(range_dir({bx, by, bz, ex, ey, ez}));
        n_sent++;
      end
      if (!in_valid || in_ready) begin
        if (idle_in != 0) begin
          idle_in--;
          go_idle = 1;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
          idle_in = $urandom_range(0, 15);
          go_idle = 1;
        end else begin
          go_idle = 0;
        end
        if (pending_q.size() != 0 && !go_idle) begin
          c = pending_q.pop_front();
          in_valid <= 1;
          {bx, by, bz, ex, ey, ez} <= c;
        end else begin
          in_valid <= 0;
          if (pending_q.size() == 0) stim_done <= 1;
        end
        quiet <= (pending_q.size() < 300);
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    range_dir_t e, a;
    if (rst_n && out_valid && out_ready) begin
      a = '{dist_o, dx_o, dy_o, dz_o, zero_o};
      n_got++;
      if (a.zero) n_zero++;
      if (expected_q.size() == 0) begin
        n_err++;
        if (n_err <= 10) $display("unexpected result %p", a);
      end else begin
        e = expected_q.pop_front();
        if (a !== e) begin
          n_err++;
          if (n_err <= 10) $display("mismatch: exp %p got %p", e, a);
        end
      end
    end
  end

  // receiver stalls
  initial begin
    @(posedge rst_n);
    repeat (100) @(posedge clk);
    hold_long = 1;
    repeat (200) @(posedge clk);
    hold_long = 0;
  end

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_ready <= 0;
    end else if (hold_long) begin
      out_ready <= 0;
    end else if (quiet) begin
      out_ready <= 1;
    end else if (idle_out != 0) begin
      out_ready <= 0;
      idle_out--;
    end else if ($urandom_range(0, 7) == 0) begin
      out_ready <= 0;
      idle_out = $urandom_range(0, 15);
    end else begin
      out_ready <= 1;
    end
  end

  initial begin
    rst_n = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1;
    wait (stim_done && !in_valid && expected_q.size() == 0);
    repeat (PipeLat + 10) @(posedge clk);
    $display("sent %0d requests, checked %0d results (%0d zero-distance)",
             n_sent, n_got, n_zero);
    if (n_err == 0 && expected_q.size() == 0) begin
      $display("[range_and_direction_3d] OK");
    end else begin
      $display("%0d mismatches", n_err);
      $display("[range_and_direction_3d] ERROR");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("[range_and_direction_3d] ERROR");
    $finish;
  end
endmodule
